@@ rtl/tvdp_pkg.sv @@
// Shared constants for the total-variation dual projection step.
// Used by the square-root lanes, the divider lanes and the top level.
`default_nettype none
package tvdp_pkg;
  localparam int VW = 16;
  localparam int FB = 12;
  localparam int STEP_W = 16;
  localparam int NUM_W = VW + STEP_W + 1;
  localparam int A_W = VW + STEP_W;
  localparam int SQ_W = 2 * VW;
  localparam int XW = VW + FB + 1;
  localparam int QW = VW + 1;
  localparam int LAT = VW + QW + 3;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(8192);
endpackage
`default_nettype wire

@@ rtl/tvdp_sqrt_lane.sv @@
// Pipelined integer square root, one root bit per stage, with two numerators
// carried alongside. Depends on tvdp_pkg.
`default_nettype none
module tvdp_sqrt_lane (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic [tvdp_pkg::SQ_W-1:0]        sq_i,
  input  wire logic signed [tvdp_pkg::NUM_W-1:0] num0_i,
  input  wire logic signed [tvdp_pkg::NUM_W-1:0] num1_i,
  output logic [tvdp_pkg::VW-1:0]               root_o,
  output logic signed [tvdp_pkg::NUM_W-1:0]     num0_o,
  output logic signed [tvdp_pkg::NUM_W-1:0]     num1_o
);
  import tvdp_pkg::*;

  logic [SQ_W-1:0]         sq_s   [VW+1];
  logic [VW+1:0]           rem_s  [VW+1];
  logic [VW-1:0]           root_s [VW+1];
  logic signed [NUM_W-1:0] n0_s   [VW+1];
  logic signed [NUM_W-1:0] n1_s   [VW+1];

  assign sq_s[0]   = sq_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign n0_s[0]   = num0_i;
  assign n1_s[0]   = num1_i;

  for (genvar i = 0; i < VW; i++) begin : g_stage
    localparam int K = VW - 1 - i;
    logic [VW+3:0] cat;
    logic [VW+3:0] trial;
    logic [VW+1:0] rem_d;
    logic [VW-1:0] root_d;

    always_comb begin
      cat   = {rem_s[i], sq_s[i][2*K+1 -: 2]};
      trial = {2'b00, root_s[i], 2'b01};
      if (cat >= trial) begin
        rem_d  = (VW+2)'(cat - trial);
        root_d = {root_s[i][VW-2:0], 1'b1};
      end else begin
        rem_d  = cat[VW+1:0];
        root_d = {root_s[i][VW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_s[i+1]   <= sq_s[i];
        rem_s[i+1]  <= rem_d;
        root_s[i+1] <= root_d;
        n0_s[i+1]   <= n0_s[i];
        n1_s[i+1]   <= n1_s[i];
      end
    end
  end

  assign root_o = root_s[VW];
  assign num0_o = n0_s[VW];
  assign num1_o = n1_s[VW];
endmodule
`default_nettype wire

@@ rtl/tvdp_div_lane.sv @@
// Pipelined restoring divider for one component: clamps the magnitude, divides
// with rounding, then saturates. Depends on tvdp_pkg.
`default_nettype none
module tvdp_div_lane (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [tvdp_pkg::NUM_W-1:0] num_i,
  input  wire logic [tvdp_pkg::VW-1:0]           mag_i,
  output logic [tvdp_pkg::VW-1:0]                res_o,
  output logic                                   sat_o
);
  import tvdp_pkg::*;

  logic              neg_c;
  logic [A_W-1:0]    a_c;
  logic [VW-1:0]     m_c;
  logic [A_W+FB+1:0] d_c;

  always_comb begin
    neg_c = num_i[NUM_W-1];
    a_c   = neg_c ? A_W'(-num_i) : A_W'(num_i);
    m_c   = (mag_i < VW'(1 << FB)) ? VW'(1 << FB) : mag_i;
    d_c   = (A_W+FB+2)'({a_c, {(FB+1){1'b0}}}) + (A_W+FB+2)'({m_c, {STEP_W{1'b0}}});
  end

  logic [XW-1:0] x_s   [QW+1];
  logic [VW-1:0] m_s   [QW+1];
  logic [VW-1:0] r_s   [QW+1];
  logic [QW-1:0] q_s   [QW+1];
  logic          neg_s [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_s[0]   <= d_c[A_W+FB+1 -: XW];
      m_s[0]   <= m_c;
      neg_s[0] <= neg_c;
    end
  end

  assign r_s[0] = VW'(x_s[0][XW-1:QW]);
  assign q_s[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [VW:0]   t;
    logic [VW-1:0] r_d;
    logic          qb;

    always_comb begin
      t  = {r_s[j], x_s[j][QW-1-j]};
      qb = (t >= {1'b0, m_s[j]});
      r_d = qb ? VW'(t - {1'b0, m_s[j]}) : t[VW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_s[j+1]   <= x_s[j];
        m_s[j+1]   <= m_s[j];
        r_s[j+1]   <= r_d;
        q_s[j+1]   <= {q_s[j][QW-2:0], qb};
        neg_s[j+1] <= neg_s[j];
      end
    end
  end

  logic [QW-1:0] q;
  assign q = q_s[QW];

  always_comb begin
    if (!neg_s[QW]) begin
      sat_o = (q[QW-1:VW-1] != '0);
      res_o = sat_o ? {1'b0, {(VW-1){1'b1}}} : q[VW-1:0];
    end else begin
      sat_o = (q > QW'(1 << (VW-1)));
      res_o = sat_o ? {1'b1, {(VW-1){1'b0}}} : VW'(-q);
    end
  end
endmodule
`default_nettype wire

@@ rtl/tv_dual_projection_step.sv @@
// Top level of the dual projection step: products, two root lanes, four
// divider lanes and the merging output register. Depends on tvdp_pkg.
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_stall_o | dual_*_i, grad_*_i
//  out     | source    | out_valid_o/out_stall_i| new_dual_*_o, saturated_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_step_size_i
//
// One transaction is accepted per cycle while the output is not stalled; data passes through the
// product register, the bit-per-stage root and divider pipelines and the output register. Reset clears
// valid bits and restores the step size. An output stall while a result is valid freezes the whole pipeline.
`default_nettype none
module tv_dual_projection_step (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [tvdp_pkg::VW-1:0] dual_a_x_i,
  input  wire logic signed [tvdp_pkg::VW-1:0] dual_a_y_i,
  input  wire logic signed [tvdp_pkg::VW-1:0] dual_b_x_i,
  input  wire logic signed [tvdp_pkg::VW-1:0] dual_b_y_i,
  input  wire logic signed [tvdp_pkg::VW-1:0] grad_a_x_i,
  input  wire logic signed [tvdp_pkg::VW-1:0] grad_a_y_i,
  input  wire logic signed [tvdp_pkg::VW-1:0] grad_b_x_i,
  input  wire logic signed [tvdp_pkg::VW-1:0] grad_b_y_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [tvdp_pkg::VW-1:0]   new_dual_a_x_o,
  output logic signed [tvdp_pkg::VW-1:0]   new_dual_a_y_o,
  output logic signed [tvdp_pkg::VW-1:0]   new_dual_b_x_o,
  output logic signed [tvdp_pkg::VW-1:0]   new_dual_b_y_o,
  output logic                             saturated_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tvdp_pkg::STEP_W-1:0] cfg_step_size_i
);
  import tvdp_pkg::*;

  logic [STEP_W-1:0] step_q;
  logic [LAT-1:0]    vld_q;
  logic              en;

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      vld_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_step_size_i;
      end
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
    end
  end

  function automatic logic signed [NUM_W-1:0] numer(
    input logic signed [VW-1:0] x, input logic signed [VW-1:0] g,
    input logic [STEP_W-1:0] s);
    logic signed [NUM_W-1:0] p;
    p = $signed({1'b0, s}) * g;
    return $signed({x[VW-1], x, {STEP_W{1'b0}}}) + p;
  endfunction

  logic [SQ_W-1:0]         sqa_q, sqb_q;
  logic signed [NUM_W-1:0] nax_q, nay_q, nbx_q, nby_q;
  logic signed [SQ_W-1:0]  axx, ayy, bxx, byy;

  assign axx = dual_a_x_i * dual_a_x_i;
  assign ayy = dual_a_y_i * dual_a_y_i;
  assign bxx = dual_b_x_i * dual_b_x_i;
  assign byy = dual_b_y_i * dual_b_y_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa_q <= SQ_W'($unsigned(axx)) + SQ_W'($unsigned(ayy));
      sqb_q <= SQ_W'($unsigned(bxx)) + SQ_W'($unsigned(byy));
      nax_q <= numer(dual_a_x_i, grad_a_x_i, step_q);
      nay_q <= numer(dual_a_y_i, grad_a_y_i, step_q);
      nbx_q <= numer(dual_b_x_i, grad_b_x_i, step_q);
      nby_q <= numer(dual_b_y_i, grad_b_y_i, step_q);
    end
  end

  logic [VW-1:0]           ma, mb;
  logic signed [NUM_W-1:0] dax, day, dbx, dby;

  tvdp_sqrt_lane u_sqrt_a (.clk_i, .en_i(en), .sq_i(sqa_q), .num0_i(nax_q),
    .num1_i(nay_q), .root_o(ma), .num0_o(dax), .num1_o(day));
  tvdp_sqrt_lane u_sqrt_b (.clk_i, .en_i(en), .sq_i(sqb_q), .num0_i(nbx_q),
    .num1_i(nby_q), .root_o(mb), .num0_o(dbx), .num1_o(dby));

  logic [VW-1:0] rax, ray, rbx, rby;
  logic          sax, say, sbx, sby;

  tvdp_div_lane u_div_ax (.clk_i, .en_i(en), .num_i(dax), .mag_i(ma),
    .res_o(rax), .sat_o(sax));
  tvdp_div_lane u_div_ay (.clk_i, .en_i(en), .num_i(day), .mag_i(ma),
    .res_o(ray), .sat_o(say));
  tvdp_div_lane u_div_bx (.clk_i, .en_i(en), .num_i(dbx), .mag_i(mb),
    .res_o(rbx), .sat_o(sbx));
  tvdp_div_lane u_div_by (.clk_i, .en_i(en), .num_i(dby), .mag_i(mb),
    .res_o(rby), .sat_o(sby));

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_dual_a_x_o <= $signed(rax);
      new_dual_a_y_o <= $signed(ray);
      new_dual_b_x_o <= $signed(rbx);
      new_dual_b_y_o <= $signed(rby);
      saturated_o    <= sax | say | sbx | sby;
    end
  end
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the total-variation dual projection step.
// Drives directed and random transactions with random idling on both channels,
// predicts every result in place and compares it as a whole. Depends on tvdp_pkg.
`timescale 1ns / 1ps
module tb;
  import tvdp_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 2 * LAT;
  localparam int N_RANDOM = 880;

  typedef struct packed {
    logic signed [VW-1:0] ax, ay, bx, by, gax, gay, gbx, gby;
  } pixel_t;

  typedef struct packed {
    logic signed [VW-1:0] ax, ay, bx, by;
    logic sat;
  } dual_t;

  typedef struct {
    pixel_t pix;
    logic check_fixed;
    dual_t fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pixel_t in_pix = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dual_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [STEP_W-1:0] cfg_step = '0;

  logic [STEP_W-1:0] tau_model = STEP_RESET;
  dual_t pending_duals[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit out_busy = 1'b1;
  row_t rows[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tv_dual_projection_step i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .dual_a_x_i(in_pix.ax), .dual_a_y_i(in_pix.ay),
    .dual_b_x_i(in_pix.bx), .dual_b_y_i(in_pix.by),
    .grad_a_x_i(in_pix.gax), .grad_a_y_i(in_pix.gay),
    .grad_b_x_i(in_pix.gbx), .grad_b_y_i(in_pix.gby),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .new_dual_a_x_o(out_res.ax), .new_dual_a_y_o(out_res.ay),
    .new_dual_b_x_o(out_res.bx), .new_dual_b_y_o(out_res.by),
    .saturated_o(out_res.sat),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_step_size_i(cfg_step)
  );

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned norm_floor_one(longint x, longint y);
    longint unsigned m;
    m = root_floor(longint'(x * x + y * y));
    return (m < (64'd1 << FB)) ? (64'd1 << FB) : m;
  endfunction

  function automatic logic [VW-1:0] project_comp(longint c, longint g,
      longint unsigned mag, logic [STEP_W-1:0] tau, ref logic sat);
    longint num;
    longint unsigned a, den, q, r;
    longint res, maxv, minv;
    num = c * 65536 + longint'(tau) * g;
    a = (num < 0) ? -num : num;
    den = mag << STEP_W;
    q = a / den;
    r = a % den;
    for (int i = 0; i < FB; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    if (r * 2 >= den) q++;
    res = (num < 0) ? -longint'(q) : longint'(q);
    maxv = (64'sd1 <<< (VW - 1)) - 1;
    minv = -maxv - 1;
    if (res > maxv) begin
      res = maxv;
      sat = 1'b1;
    end else if (res < minv) begin
      res = minv;
      sat = 1'b1;
    end
    return res[VW-1:0];
  endfunction

  function automatic dual_t predict_dual(pixel_t p, logic [STEP_W-1:0] tau);
    dual_t d;
    logic s;
    longint unsigned ma, mb;
    s = 1'b0;
    ma = norm_floor_one(p.ax, p.ay);
    mb = norm_floor_one(p.bx, p.by);
    d.ax = project_comp(p.ax, p.gax, ma, tau, s);
    d.ay = project_comp(p.ay, p.gay, ma, tau, s);
    d.bx = project_comp(p.bx, p.gbx, mb, tau, s);
    d.by = project_comp(p.by, p.gby, mb, tau, s);
    d.sat = s;
    return d;
  endfunction

  function automatic logic signed [VW-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'(int'($urandom_range(0, 8192)) - 4096);
      2: return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = {rand_val(), rand_val(), rand_val(), rand_val(),
         rand_val(), rand_val(), rand_val(), rand_val()};
    return p;
  endfunction

  task automatic send_pixel(pixel_t p);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_pix <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_duals.push_back(predict_dual(p, tau_model));
    @(negedge clk);
  endtask

  task automatic write_tau(logic [STEP_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_duals.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_step <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tau_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(pixel_t p, logic chk, dual_t d);
    row_t r;
    r.pix = p;
    r.check_fixed = chk;
    r.fixed = d;
    rows.push_back(r);
  endtask

  always @(negedge clk) begin
    if (!out_busy || quiet_phase) begin
      out_stall <= 1'b0;
      if (!quiet_phase && $urandom_range(0, 7) == 0) out_busy = 1'b1;
    end else begin
      out_stall <= 1'b1;
      repeat ($urandom_range(0, 9)) @(negedge clk);
      out_busy = 1'b0;
    end
  end

  always @(posedge clk) begin
    dual_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_duals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res);
      end else begin
        want = pending_duals.pop_front();
        if (out_res !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tv_dual_projection_step regression: fail");
      $finish;
    end
  end

  initial begin
    logic [STEP_W-1:0] taus[5];
    dual_t d;
    taus = '{16'hffff, 16'h0000, 16'h0001, 16'h8000, 16'h1234};
    d = '0;
    // Zero vectors and zero gradients give zero with the clamp to one.
    add_row('0, 1'b1, '0);
    // Unit vectors with no gradient reproduce themselves.
    add_row({16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 64'd0}, 1'b1,
            '{16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 1'b0});
    // Extreme values in the gradients and vectors, checked against the prediction.
    add_row({64'd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, d);
    add_row({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'sh8000, 16'sh8000}, 1'b0, d);
    add_row({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 64'd0}, 1'b0, d);
    add_row({16'sd100, -16'sd50, 16'sd2000, 16'sd3000, 16'sh7fff, 16'sh8000,
             -16'sd1, 16'sd1}, 1'b0, d);
    for (int i = 0; i < 10; i++) add_row(rand_pixel(), 1'b0, d);

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (rows[i]) begin
      send_pixel(rows[i].pix);
      if (rows[i].check_fixed) begin
        pending_duals.pop_back();
        pending_duals.push_back(rows[i].fixed);
      end
    end
    foreach (taus[k]) begin
      write_tau(taus[k]);
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        if (k == 4 && i == N_RANDOM / 10) quiet_phase = 1'b1;
        send_pixel(rand_pixel());
      end
    end
    in_valid <= 1'b0;
    while (pending_duals.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0)
      $display("tv_dual_projection_step regression: pass");
    else
      $display("tv_dual_projection_step regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/tvdp_pkg.sv
rtl/tvdp_sqrt_lane.sv
rtl/tvdp_div_lane.sv
rtl/tv_dual_projection_step.sv
bench/tb.sv
